// ----- rtl/wptf_pkg.sv -----
// ----------------------------------------------------------------------------
// wptf_pkg
// Shared types and constants for the rotate-then-drive waypoint follower.
// ----------------------------------------------------------------------------
`default_nettype none

package wptf_pkg;

    localparam int MAX_WAYPOINTS = 256;
    localparam int WP_AW         = $clog2(MAX_WAYPOINTS);
    localparam int WP_CNT_W      = WP_AW + 1;
    localparam int WP_W          = 64;

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_ODOM = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FWD_SPEED  = 2'd0;
    localparam logic [1:0] CFG_TURN_SPEED = 2'd1;
    localparam logic [1:0] CFG_REACH_TOL  = 2'd2;
    localparam logic [1:0] CFG_HEAD_TOL   = 2'd3;

    localparam logic [14:0] FWD_SPEED_RST  = 15'd328;
    localparam logic [14:0] TURN_SPEED_RST = 15'd1638;
    localparam logic [30:0] REACH_TOL_RST  = 31'd7864;
    localparam logic [14:0] HEAD_TOL_RST   = 15'd1229;

    localparam int CX_W = 46;   // CORDIC x/y datapath
    localparam int CZ_W = 20;   // CORDIC angle accumulator, 2^-16 rad

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [CZ_W-1:0] HALF_PI_Q16 = 20'sd102944;

    // atan(2^-i) in units of 2^-16 rad
    function automatic logic signed [CZ_W-1:0] atan_tab(input logic [3:0] i);
        logic signed [CZ_W-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            4'd15:   v = 20'sd2;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wptf_ram.sv -----
// ----------------------------------------------------------------------------
// wptf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wptf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/waypoint_rotate_then_drive_follower.sv -----
// ----------------------------------------------------------------------------
// waypoint_rotate_then_drive_follower
// Rotate-then-drive waypoint follower with a shared multiplier and CORDIC.
// ----------------------------------------------------------------------------
// One item is in work at a time; s_tready is high only while the sequencer is
// idle. A load is taken in the idle state; the first load of a path also
// passes the emit state since it queues a stop command. An odometry update
// runs the quaternion products on the shared multiplier, the normalize shifts
// and 16 CORDIC iterations on the one shift-add unit, plus a rounding step.
// A control tick that reaches the waypoint takes the waypoint RAM read, offset
// sums and three squares on the shared multiplier; otherwise a command is
// computed through the same CORDIC. Stop commands for a finished path go from
// the tick through the emit state into the output register. A result is held
// in the output register until taken; the next item is accepted meanwhile, and
// the sequencer waits only if that item has a result of its own.
`default_nettype none

module waypoint_rotate_then_drive_follower
    import wptf_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
    input  wire logic [1:0]   s_tuser,   // operation
    input  wire logic         s_tlast,   // final_waypoint
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // linear_velocity, angular_velocity, zero pad
    output logic              m_tlast,   // path_done
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_EMIT,
        ST_T_SUM, ST_T_DIFF, ST_T_CHK,
        ST_T_SQ0, ST_T_SQ1, ST_T_SQ2, ST_T_SQ3,
        ST_O_M0, ST_O_M1, ST_O_M2, ST_O_M3, ST_O_M4,
        ST_NORM, ST_CORD, ST_FIN
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [14:0] fwd_speed_reg, turn_speed_reg, head_tol_reg;
    logic [30:0] reach_tol_reg;

    // follower state
    logic                odom_seen_reg, odom_seen_next;
    logic                armed_reg, armed_next;
    logic                loading_reg, loading_next;
    logic                started_reg, started_next;
    logic [WP_CNT_W-1:0] count_reg, count_next;
    logic [WP_CNT_W-1:0] cur_reg, cur_next;
    logic signed [31:0]  robot_x_reg, robot_x_next, robot_y_reg, robot_y_next;
    logic signed [15:0]  heading_reg, heading_next;
    logic signed [32:0]  off_x_reg, off_x_next, off_y_reg, off_y_next;

    // work registers
    logic                is_tick_reg, is_tick_next;
    logic signed [15:0]  qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [15:0]  qx_next, qy_next, qz_next, qw_next;
    logic signed [33:0]  sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic signed [CX_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [CZ_W-1:0] z_reg, z_next;
    logic [3:0]          step_reg, step_next;
    logic signed [63:0]  acc_reg, acc_next;
    logic signed [63:0]  prod_reg;

    // pending result and output register
    logic [14:0]         res_lin_reg, res_lin_next;
    logic signed [15:0]  res_ang_reg, res_ang_next;
    logic                res_done_reg, res_done_next;
    logic                m_valid_reg, m_valid_next;
    logic [14:0]         m_lin_reg, m_lin_next;
    logic signed [15:0]  m_ang_reg, m_ang_next;
    logic                m_done_reg, m_done_next;

    // waypoint RAM
    logic             ram_we;
    logic [WP_AW-1:0] ram_waddr;
    logic [WP_W-1:0]  ram_rdata;

    wptf_ram #(
        .WIDTH (WP_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_wp_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_tdata[31:0], s_tdata[63:32]}),
        .raddr (cur_reg[WP_AW-1:0]),
        .rdata (ram_rdata)
    );

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    // datapath helpers
    logic signed [CX_W-1:0] abs_x, abs_y, mag_m, xs, ys;
    logic signed [CZ_W-1:0] z_rnd;
    logic signed [15:0]     atan_res;
    logic signed [17:0]     err_raw, err_w, err_abs, err_p1;
    logic                   s_acc;
    logic                   wp_reach;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, m_ang_reg, m_lin_reg};
    assign m_tlast   = m_done_reg;

    assign abs_x = x_reg[CX_W-1] ? -x_reg : x_reg;
    assign abs_y = y_reg[CX_W-1] ? -y_reg : y_reg;
    assign mag_m = (abs_x > abs_y) ? abs_x : abs_y;
    assign xs    = x_reg >>> step_reg;
    assign ys    = y_reg >>> step_reg;

    assign z_rnd    = z_reg + CZ_W'(4);
    assign atan_res = z_rnd[18:3];
    assign err_raw  = 18'(atan_res) - 18'(heading_reg);
    always_comb begin
        if (err_raw > PI_Q13) begin
            err_w = err_raw - TWO_PI_Q13;
        end else if (err_raw < -PI_Q13) begin
            err_w = err_raw + TWO_PI_Q13;
        end else begin
            err_w = err_raw;
        end
    end
    assign err_abs = err_w[17] ? -err_w : err_w;
    assign err_p1  = err_w + 18'sd1;

    assign wp_reach = (abs_x < CX_W'(reach_tol_reg)) && (abs_y < CX_W'(reach_tol_reg));

    always_comb begin
        case (state_reg)
            ST_O_M0: begin mul_a = 33'(qw_reg); mul_b = 33'(qz_reg); end
            ST_O_M1: begin mul_a = 33'(qx_reg); mul_b = 33'(qy_reg); end
            ST_O_M2: begin mul_a = 33'(qy_reg); mul_b = 33'(qy_reg); end
            ST_O_M3: begin mul_a = 33'(qz_reg); mul_b = 33'(qz_reg); end
            ST_T_SQ0: begin mul_a = abs_x[32:0]; mul_b = abs_x[32:0]; end
            ST_T_SQ1: begin mul_a = abs_y[32:0]; mul_b = abs_y[32:0]; end
            default: begin
                mul_a = $signed({2'b00, reach_tol_reg});
                mul_b = $signed({2'b00, reach_tol_reg});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_speed_reg  <= FWD_SPEED_RST;
            turn_speed_reg <= TURN_SPEED_RST;
            reach_tol_reg  <= REACH_TOL_RST;
            head_tol_reg   <= HEAD_TOL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FWD_SPEED:  fwd_speed_reg  <= cfg_data[14:0];
                CFG_TURN_SPEED: turn_speed_reg <= cfg_data[14:0];
                CFG_REACH_TOL:  reach_tol_reg  <= cfg_data[30:0];
                CFG_HEAD_TOL:   head_tol_reg   <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        odom_seen_next = odom_seen_reg;
        armed_next     = armed_reg;
        loading_next   = loading_reg;
        started_next   = started_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        robot_x_next   = robot_x_reg;
        robot_y_next   = robot_y_reg;
        heading_next   = heading_reg;
        off_x_next     = off_x_reg;
        off_y_next     = off_y_reg;
        is_tick_next   = is_tick_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qz_next        = qz_reg;
        qw_next        = qw_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        res_lin_next   = res_lin_reg;
        res_ang_next   = res_ang_reg;
        res_done_next  = res_done_reg;
        m_valid_next   = m_valid_reg;
        m_lin_next     = m_lin_reg;
        m_ang_next     = m_ang_reg;
        m_done_next    = m_done_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        OP_ODOM: begin
                            robot_x_next   = $signed(s_tdata[31:0]);
                            robot_y_next   = $signed(s_tdata[63:32]);
                            qx_next        = $signed(s_tdata[79:64]);
                            qy_next        = $signed(s_tdata[95:80]);
                            qz_next        = $signed(s_tdata[111:96]);
                            qw_next        = $signed(s_tdata[127:112]);
                            odom_seen_next = 1'b1;
                            is_tick_next   = 1'b0;
                            state_next     = ST_O_M0;
                        end
                        OP_LOAD: begin
                            if (!loading_reg) begin
                                ram_we        = 1'b1;
                                ram_waddr     = '0;
                                count_next    = WP_CNT_W'(1);
                                cur_next      = '0;
                                off_x_next    = 33'(robot_x_reg) - 33'($signed(s_tdata[31:0]));
                                off_y_next    = 33'(robot_y_reg) - 33'($signed(s_tdata[63:32]));
                                armed_next    = s_tlast;
                                started_next  = s_tlast;
                                loading_next  = !s_tlast;
                                res_lin_next  = '0;
                                res_ang_next  = '0;
                                res_done_next = 1'b0;
                                state_next    = ST_EMIT;
                            end else begin
                                if (count_reg < WP_CNT_W'(MAX_WAYPOINTS)) begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = count_reg[WP_AW-1:0];
                                    count_next = count_reg + WP_CNT_W'(1);
                                end
                                if (s_tlast) begin
                                    loading_next = 1'b0;
                                    armed_next   = 1'b1;
                                    started_next = 1'b1;
                                end
                            end
                        end
                        OP_TICK: begin
                            is_tick_next = 1'b1;
                            if (armed_reg && odom_seen_reg && count_reg != '0) begin
                                if (cur_reg >= count_reg) begin
                                    res_lin_next  = '0;
                                    res_ang_next  = '0;
                                    res_done_next = started_reg;
                                    armed_next    = 1'b0;
                                    started_next  = 1'b0;
                                    state_next    = ST_EMIT;
                                end else begin
                                    // RAM read of the current waypoint lands next cycle
                                    state_next = ST_T_SUM;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_lin_next   = res_lin_reg;
                    m_ang_next   = res_ang_reg;
                    m_done_next  = res_done_reg;
                    state_next   = ST_IDLE;
                end
            end

            ST_T_SUM: begin
                sum_x_next = 34'($signed(ram_rdata[63:32])) + 34'(off_x_reg);
                sum_y_next = 34'($signed(ram_rdata[31:0])) + 34'(off_y_reg);
                state_next = ST_T_DIFF;
            end

            ST_T_DIFF: begin
                x_next     = CX_W'(sum_x_reg) - CX_W'(robot_x_reg);
                y_next     = CX_W'(sum_y_reg) - CX_W'(robot_y_reg);
                state_next = ST_T_CHK;
            end

            ST_T_CHK: begin
                state_next = wp_reach ? ST_T_SQ0 : ST_NORM;
            end

            ST_T_SQ0: state_next = ST_T_SQ1;
            ST_T_SQ1: begin
                acc_next   = prod_reg;
                state_next = ST_T_SQ2;
            end
            ST_T_SQ2: begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_T_SQ3;
            end
            ST_T_SQ3: begin
                // prod_reg now holds the squared tolerance
                if ($unsigned(acc_reg) < $unsigned(prod_reg)) begin
                    cur_next   = cur_reg + WP_CNT_W'(1);
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_NORM;
                end
            end

            ST_O_M0: state_next = ST_O_M1;
            ST_O_M1: begin
                acc_next   = prod_reg;
                state_next = ST_O_M2;
            end
            ST_O_M2: begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_O_M3;
            end
            ST_O_M3: begin
                y_next     = CX_W'(acc_reg) <<< 1;
                acc_next   = prod_reg;
                state_next = ST_O_M4;
            end
            ST_O_M4: begin
                x_next     = (CX_W'(1) <<< 28) - (CX_W'(acc_reg + prod_reg) <<< 1);
                state_next = ST_NORM;
            end

            ST_NORM: begin
                if (x_reg == '0 && y_reg == '0) begin
                    z_next     = '0;
                    state_next = ST_FIN;
                end else if (mag_m < (CX_W'(1) <<< 32)) begin
                    x_next = x_reg <<< 8;
                    y_next = y_reg <<< 8;
                end else if (mag_m < (CX_W'(1) <<< 40)) begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end else begin
                    // fold left half-plane into the right one
                    step_next  = '0;
                    state_next = ST_CORD;
                    if (x_reg[CX_W-1]) begin
                        if (!y_reg[CX_W-1]) begin
                            x_next = y_reg;
                            y_next = -x_reg;
                            z_next = HALF_PI_Q16;
                        end else begin
                            x_next = -y_reg;
                            y_next = x_reg;
                            z_next = -HALF_PI_Q16;
                        end
                    end else begin
                        z_next = '0;
                    end
                end
            end

            ST_CORD: begin
                if (y_reg > 0) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_tab(step_reg);
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_tab(step_reg);
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15) begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                if (!is_tick_reg) begin
                    heading_next = atan_res;
                    state_next   = ST_IDLE;
                end else begin
                    if (err_abs > 18'(head_tol_reg)) begin
                        res_lin_next = '0;
                        res_ang_next = err_w[17] ? -16'(turn_speed_reg) : 16'(turn_speed_reg);
                    end else begin
                        res_lin_next = fwd_speed_reg;
                        res_ang_next = err_p1[16:1];
                    end
                    res_done_next = 1'b0;
                    state_next    = ST_EMIT;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            odom_seen_reg <= 1'b0;
            armed_reg     <= 1'b0;
            loading_reg   <= 1'b0;
            started_reg   <= 1'b0;
            count_reg     <= '0;
            cur_reg       <= '0;
            robot_x_reg   <= '0;
            robot_y_reg   <= '0;
            heading_reg   <= '0;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            odom_seen_reg <= odom_seen_next;
            armed_reg     <= armed_next;
            loading_reg   <= loading_next;
            started_reg   <= started_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            robot_x_reg   <= robot_x_next;
            robot_y_reg   <= robot_y_next;
            heading_reg   <= heading_next;
            off_x_reg     <= off_x_next;
            off_y_reg     <= off_y_next;
            m_valid_reg   <= m_valid_next;
        end
        is_tick_reg  <= is_tick_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        qz_reg       <= qz_next;
        qw_reg       <= qw_next;
        sum_x_reg    <= sum_x_next;
        sum_y_reg    <= sum_y_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        res_lin_reg  <= res_lin_next;
        res_ang_reg  <= res_ang_next;
        res_done_reg <= res_done_next;
        m_lin_reg    <= m_lin_next;
        m_ang_reg    <= m_ang_next;
        m_done_reg   <= m_done_next;
    end

    // an armed path always holds at least one waypoint
    a_armed_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> count_reg != '0)
        else $error("armed with empty path");

    // the follower never advances past one beyond the last waypoint
    a_cur_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= count_reg)
        else $error("current index beyond waypoint count");

    // the last CORDIC iteration hands over to rounding
    a_cordic_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD && step_reg == 4'd15) |=> state_reg == ST_FIN)
        else $error("CORDIC did not finish after 16 steps");

    // a path-done transfer is always a full stop
    a_done_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> (m_lin_reg == '0 && m_ang_reg == '0))
        else $error("path done with nonzero command");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotate-then-drive waypoint follower. A queue of
// items drives the input stream; a predictor computes each velocity command
// and a monitor compares results as they are transferred out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import wptf_pkg::*;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic               fin;
    } item_t;

    typedef struct packed {
        logic [14:0]        lin;
        logic signed [15:0] ang;
        logic               done;
    } cmd_t;

    localparam logic [3:0] FL_ODOM    = 4'd1;
    localparam logic [3:0] FL_ARMED   = 4'd2;
    localparam logic [3:0] FL_LOADING = 4'd4;
    localparam logic [3:0] FL_STARTED = 4'd8;
    localparam longint LIMIT_CYCLES   = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    waypoint_rotate_then_drive_follower i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial forever #1 aclk = ~aclk;

    // predictor state
    logic [63:0] path_mem [MAX_WAYPOINTS];
    int unsigned path_len, path_idx;
    logic signed [31:0] pose_x, pose_y, anchor_x, anchor_y, start_x, start_y;
    int signed heading;
    logic [3:0] flags;
    logic [14:0] fwd_speed, turn_rate, head_tol;
    logic [30:0] reach_tol;

    item_t pending_items[$];
    cmd_t expected_cmds[$];
    int send_idle_pct, recv_idle_pct;
    int mismatches;
    longint cycles;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int signed cordic_atan2(longint y, longint x);
        longint z, t, xs, ys, m, ax, ay;
        longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        z = 0;
        if (x == 0 && y == 0) return 0;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        m = ax > ay ? ax : ay;
        while (m < (64'sd1 <<< 40)) begin
            x = x * 2; y = y * 2; m = m * 2;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 102944;
            end else begin
                t = x; x = -y; y = t; z = -102944;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += tab[i];
            end else begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        return int'(asr(z + 4, 3));
    endfunction

    task automatic predictor_reset();
        path_len = 0; path_idx = 0;
        pose_x = 0; pose_y = 0; heading = 0;
        anchor_x = 0; anchor_y = 0; start_x = 0; start_y = 0;
        flags = '0;
        fwd_speed = FWD_SPEED_RST; turn_rate = TURN_SPEED_RST;
        reach_tol = REACH_TOL_RST; head_tol = HEAD_TOL_RST;
    endtask

    task automatic predict_command(input item_t it);
        longint num, den, wx, wy, dx, dy, err, ax, ay, tol;
        cmd_t c;
        case (it.op)
            OP_ODOM: begin
                num = 2 * (longint'(it.qw) * it.qz + longint'(it.qx) * it.qy);
                den = (64'sd1 <<< 28) - 2 * (longint'(it.qy) * it.qy
                                              + longint'(it.qz) * it.qz);
                pose_x = it.px; pose_y = it.py;
                heading = cordic_atan2(num, den);
                flags |= FL_ODOM;
            end
            OP_LOAD: begin
                if (!(flags & FL_LOADING)) begin
                    flags &= ~(FL_ARMED | FL_STARTED);
                    path_mem[0] = {it.px, it.py};
                    path_len = 1; path_idx = 0;
                    anchor_x = pose_x; anchor_y = pose_y;
                    start_x = it.px; start_y = it.py;
                    if (it.fin) flags |= FL_ARMED | FL_STARTED;
                    else flags |= FL_LOADING;
                    c = '0;
                    expected_cmds = {expected_cmds, c};
                end else begin
                    if (path_len < MAX_WAYPOINTS) begin
                        path_mem[path_len] = {it.px, it.py};
                        path_len++;
                    end
                    if (it.fin) begin
                        flags &= ~FL_LOADING;
                        flags |= FL_ARMED | FL_STARTED;
                    end
                end
            end
            OP_TICK: begin
                if ((flags & FL_ARMED) && (flags & FL_ODOM) && path_len != 0) begin
                    if (path_idx >= path_len) begin
                        c = '0;
                        c.done = (flags & FL_STARTED) != 0;
                        flags &= ~(FL_ARMED | FL_STARTED);
                        expected_cmds = {expected_cmds, c};
                    end else begin
                        wx = longint'($signed(path_mem[path_idx][63:32]));
                        wy = longint'($signed(path_mem[path_idx][31:0]));
                        dx = longint'(anchor_x) + (wx - start_x) - pose_x;
                        dy = longint'(anchor_y) + (wy - start_y) - pose_y;
                        ax = dx < 0 ? -dx : dx;
                        ay = dy < 0 ? -dy : dy;
                        tol = longint'(reach_tol);
                        if (ax < tol && ay < tol && ax * ax + ay * ay < tol * tol) begin
                            path_idx++;
                        end else begin
                            err = cordic_atan2(dy, dx) - heading;
                            while (err > 25736) err -= 51472;
                            while (err < -25736) err += 51472;
                            if ((err < 0 ? -err : err) > head_tol) begin
                                c.lin = '0;
                                c.ang = err > 0 ? 16'(turn_rate) : -16'(turn_rate);
                                c.done = 1'b0;
                            end else begin
                                c.lin = fwd_speed;
                                c.ang = 16'(asr(err + 1, 1));
                                c.done = 1'b0;
                            end
                            expected_cmds = {expected_cmds, c};
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // stimulus builders
    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(0, 3))
            0: return 16'sd16384;
            1: return -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos(int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 400000)) - 200000);
            1: return 32'($signed($urandom_range(0, 40000)) - 20000);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_odom(logic signed [31:0] x, logic signed [31:0] y);
        item_t it;
        it = '0;
        it.op = OP_ODOM; it.px = x; it.py = y;
        it.qx = rand_quat(); it.qy = rand_quat(); it.qz = rand_quat(); it.qw = rand_quat();
        it.fin = 1'($urandom_range(0, 1));
        pending_items = {pending_items, it};
    endtask

    task automatic push_item(logic [1:0] op, logic signed [31:0] x,
                             logic signed [31:0] y, logic fin);
        item_t it;
        it.op = op; it.px = x; it.py = y;
        it.qx = 16'($urandom()); it.qy = 16'($urandom());
        it.qz = 16'($urandom()); it.qw = 16'($urandom());
        it.fin = fin;
        pending_items = {pending_items, it};
    endtask

    // a path followed by a run of ticks interleaved with random odometry updates
    task automatic push_route(int n, int mode);
        for (int i = 0; i < n; i++)
            push_item(OP_LOAD, rand_pos(mode), rand_pos(mode), i == n - 1);
        for (int i = 0; i < 3 * n + 4; i++) begin
            if ($urandom_range(0, 2) == 0) push_odom(rand_pos(mode), rand_pos(mode));
            else push_item(OP_TICK, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
        end
    endtask

    // input handshake seen at the rising edge, used by the driver afterwards
    logic s_tready_seen = 1'b0;
    always @(posedge aclk) s_tready_seen <= s_tvalid && s_tready;

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                // no action here; the driver tracks taken transfers through s_tready_seen
            end
            if (!s_tvalid || s_tready_seen) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item_t it;
                    it = pending_items.pop_front();
                    s_tdata <= {it.qw, it.qz, it.qy, it.qx, it.py, it.px};
                    s_tuser <= it.op;
                    s_tlast <= it.fin;
                    s_tvalid <= 1'b1;
                    predict_command(it);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            cmd_t want;
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result lin=%0d ang=%0d done=%0d",
                             m_tdata[14:0], $signed(m_tdata[30:15]), m_tlast);
            end else begin
                want = expected_cmds.pop_front();
                if (m_tdata[14:0] !== want.lin || m_tdata[30:15] !== want.ang
                    || m_tlast !== want.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected lin=%0d ang=%0d done=%0d, got lin=%0d ang=%0d done=%0d",
                                 want.lin, want.ang, want.done, m_tdata[14:0],
                                 $signed(m_tdata[30:15]), m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_cmds.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FWD_SPEED:  fwd_speed = val[14:0];
            CFG_TURN_SPEED: turn_rate = val[14:0];
            CFG_REACH_TOL:  reach_tol = val[30:0];
            default:        head_tol = val[14:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int start;
        start = pending_items.size();
        while (pending_items.size() - start < n) begin
            case ($urandom_range(0, 9))
                0: push_item(2'($urandom_range(0, 3)), $urandom(), $urandom(),
                             1'($urandom_range(0, 1)));
                1: push_route($urandom_range(1, 3), 2);
                default: push_route($urandom_range(1, 8), $urandom_range(0, 1));
            endcase
        end
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        predictor_reset();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: ticks before anything, extremes, full route, unknown op
        push_item(OP_TICK, 0, 0, 0);
        push_item(2'd3, 32'sh7fffffff, 32'sh80000000, 1);
        push_odom(32'sh80000000, 32'sh7fffffff);
        push_item(OP_LOAD, 0, 0, 1);
        push_item(OP_TICK, 0, 0, 0);
        push_item(OP_TICK, 0, 0, 0);
        push_odom(0, 0);
        push_item(OP_LOAD, 32'sh7fffffff, 32'sh80000000, 0);
        push_item(OP_LOAD, 32'sh80000000, 32'sh7fffffff, 0);
        push_item(OP_LOAD, 5000, -3000, 1);
        for (int i = 0; i < 6; i++) push_item(OP_TICK, 0, 0, i[0]);
        push_item(OP_TICK, 0, 0, 0);
        drain();

        // overfill the store: drops beyond capacity
        for (int i = 0; i < MAX_WAYPOINTS + 4; i++)
            push_item(OP_LOAD, rand_pos(1), rand_pos(1), i == MAX_WAYPOINTS + 3);
        for (int i = 0; i < 12; i++) push_item(OP_TICK, 0, 0, 0);
        drain();

        write_reg(CFG_FWD_SPEED, 32'h7fff);
        write_reg(CFG_TURN_SPEED, 32'h0);
        write_reg(CFG_REACH_TOL, 32'h0);
        write_reg(CFG_HEAD_TOL, 32'd25736);
        send_idle_pct = 16; recv_idle_pct = 48;
        random_phase(300);
        drain();

        write_reg(CFG_FWD_SPEED, 32'h0);
        write_reg(CFG_TURN_SPEED, 32'h7fff);
        write_reg(CFG_REACH_TOL, 32'h7fffffff);
        write_reg(CFG_HEAD_TOL, 32'h0);
        send_idle_pct = 48; recv_idle_pct = 16;
        random_phase(300);
        drain();

        write_reg(CFG_FWD_SPEED, 32'd328);
        write_reg(CFG_TURN_SPEED, 32'd1638);
        write_reg(CFG_REACH_TOL, 32'd30000);
        write_reg(CFG_HEAD_TOL, 32'd1229);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(900);
        drain();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/wptf_pkg.sv
rtl/wptf_ram.sv
rtl/waypoint_rotate_then_drive_follower.sv
tb/sv/testbench.sv
